// ===== hw/rtl/ddq_pkg.sv =====
// ddq_pkg: shared types, codes and the wrap-safe time compare for the deadline delay queue
`timescale 1ns / 1ps

package ddq_pkg;

   localparam int TIME_W   = 32;
   localparam int INDEX_W  = 32;
   localparam int DELAY_W  = 24;
   localparam int OCC_W    = 5;

   typedef enum logic [1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_TICK = 2'd1,
      FUNC_POP  = 2'd2,
      FUNC_GET  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOT_DUE = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      logic push_en;
      logic pop_en;
   } cell_ctrl_type;

   // a lies strictly before b when the wrapped difference is negative
   function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return diff[TIME_W-1];
   endfunction

endpackage

// ===== hw/rtl/ddq_cell.sv =====
// ddq_cell: one slot of the sorted chain, holding a due time and an index
`timescale 1ns / 1ps

module ddq_cell
   import ddq_pkg::*;
(
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic                occupied,
   input  logic [TIME_W-1:0]   new_due,
   input  logic [INDEX_W-1:0]  new_index,
   input  logic                left_match,
   input  logic [TIME_W-1:0]   left_due,
   input  logic [INDEX_W-1:0]  left_index,
   input  logic [TIME_W-1:0]   right_due,
   input  logic [INDEX_W-1:0]  right_index,
   input  logic                above_in,
   output logic                above_out,
   output logic                match,
   output logic [TIME_W-1:0]   due,
   output logic [INDEX_W-1:0]  index
);

   logic [TIME_W-1:0]  due_ff,   due_in;
   logic [INDEX_W-1:0] index_ff, index_in;

   // the new entry goes after this cell when it is not earlier than our entry
   assign match     = occupied && !earlier(new_due, due_ff);
   assign above_out = above_in | match;

   always_comb begin
      due_in   = due_ff;
      index_in = index_ff;
      if (ctrl.push_en) begin
         if (!above_out) begin
            if (left_match) begin
               due_in   = new_due;
               index_in = new_index;
            end else begin
               due_in   = left_due;
               index_in = left_index;
            end
         end
      end else if (ctrl.pop_en) begin
         due_in   = right_due;
         index_in = right_index;
      end
   end

   always_ff @(posedge clock) begin
      due_ff   <= due_in;
      index_ff <= index_in;
   end

   assign due   = due_ff;
   assign index = index_ff;

endmodule

// ===== hw/rtl/deadline_delay_queue.sv =====
// deadline_delay_queue: top level, command decode, time counter and the chain of cells
//
//   channel   ports                                            handshake
//   request   req_func, req_product_index, req_delay_ticks     start & !busy
//   result    rsp_out_index, rsp_status, rsp_occupancy         rsp_valid, one cycle
//
// one request per cycle; the result appears in the cycle after acceptance.
// push inserts into the sorted chain: every cell compares in
// parallel and the chain shifts right above the insertion point.
// a successful pop or get shifts the whole chain left by one cell.
// reset clears the entry count, the time counter and the result strobe.
// busy stays low, and results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module deadline_delay_queue
   import ddq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_func,
   input  logic [INDEX_W-1:0]         req_product_index,
   input  logic signed [DELAY_W-1:0]  req_delay_ticks,
   output logic                       rsp_valid,
   output logic [INDEX_W-1:0]         rsp_out_index,
   output logic [1:0]                 rsp_status,
   output logic [OCC_W-1:0]           rsp_occupancy
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]      count_ff, count_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic               valid_ff, valid_in;
   logic [INDEX_W-1:0] out_index_ff, out_index_in;
   status_type         status_ff, status_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;

   cell_ctrl_type      ctrl;
   func_type           func;
   logic [TIME_W-1:0]  new_due;
   logic [DELAY_W-1:0] delay_clamped;
   logic               full, empty;

   logic [TIME_W-1:0]  due_w   [DEPTH];
   logic [INDEX_W-1:0] index_w [DEPTH];
   logic [DEPTH-1:0]   match_w;
   logic [DEPTH:0]     above_w;

   assign busy = 1'b0;
   assign func = func_type'(req_func);
   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   // negative delays count as due now
   assign delay_clamped = req_delay_ticks[DELAY_W-1] ? '0 : DELAY_W'(req_delay_ticks);
   assign new_due = time_ff + TIME_W'(delay_clamped);

   assign above_w[DEPTH] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic               occ;
      logic               lm;
      logic [TIME_W-1:0]  ld, rd;
      logic [INDEX_W-1:0] li, ri;

      assign occ = (count_ff > CW'(i));

      if (i == 0) begin : g_head
         assign lm = 1'b1;
         assign ld = new_due;
         assign li = req_product_index;
      end else begin : g_body
         assign lm = match_w[i-1];
         assign ld = due_w[i-1];
         assign li = index_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign rd = '0;
         assign ri = '0;
      end else begin : g_inner
         assign rd = due_w[i+1];
         assign ri = index_w[i+1];
      end

      ddq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ),
         .new_due     (new_due),
         .new_index   (req_product_index),
         .left_match  (lm),
         .left_due    (ld),
         .left_index  (li),
         .right_due   (rd),
         .right_index (ri),
         .above_in    (above_w[i+1]),
         .above_out   (above_w[i]),
         .match       (match_w[i]),
         .due         (due_w[i]),
         .index       (index_w[i])
      );
   end

   always_comb begin
      ctrl         = '0;
      count_in     = count_ff;
      time_in      = time_ff;
      valid_in     = start;
      out_index_in = '0;
      status_in    = STATUS_OK;
      if (start) begin
         case (func)
            FUNC_PUSH: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  ctrl.push_en = 1'b1;
                  count_in     = count_ff + 1'b1;
               end
            end
            FUNC_TICK: begin
               time_in = time_ff + 1'b1;
            end
            FUNC_POP, FUNC_GET: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else if (func == FUNC_POP && earlier(time_ff, due_w[0])) begin
                  status_in = STATUS_NOT_DUE;
               end else begin
                  ctrl.pop_en  = 1'b1;
                  out_index_in = index_w[0];
                  count_in     = count_ff - 1'b1;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
      occ_in = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         time_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         time_ff  <= time_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_index_ff <= out_index_in;
      status_ff    <= status_in;
      occ_ff       <= occ_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_index = out_index_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ff;

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_valid)
      else $error("accepted request produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !start |=> !rsp_valid)
      else $error("result without a request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      start && func == FUNC_PUSH && full |=> rsp_status == STATUS_FULL && $stable(count_ff))
      else $error("push into a full queue changed state");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_out_index == '0)
      else $error("failed request returned a nonzero index");

endmodule

// ===== verif/ddq_checker.sv =====
// ddq_checker: follows the request and result channels of the deadline delay queue and checks every result
`timescale 1ns / 1ps

module ddq_checker
   import ddq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [1:0]                 req_func,
   input  logic [INDEX_W-1:0]         req_product_index,
   input  logic signed [DELAY_W-1:0]  req_delay_ticks,
   input  logic                       rsp_valid,
   input  logic [INDEX_W-1:0]         rsp_out_index,
   input  logic [1:0]                 rsp_status,
   input  logic [OCC_W-1:0]           rsp_occupancy,
   output int                         mismatch_count,
   output int                         awaited_count
);

   typedef struct packed {
      logic [INDEX_W-1:0] out_index;
      status_type         status;
      logic [OCC_W-1:0]   occupancy;
   } queue_rsp_type;

   queue_rsp_type      awaited_rsp[$];
   logic [TIME_W-1:0]  due_time   [DEPTH];
   logic [INDEX_W-1:0] held_index [DEPTH];
   int                 held_count;
   logic [TIME_W-1:0]  tick_count;

   // wrap-safe: a is strictly earlier than b when the 32-bit difference is negative
   function automatic logic lies_before(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return diff[TIME_W-1];
   endfunction

   function automatic queue_rsp_type step_queue(input func_type f,
                                                input logic [INDEX_W-1:0] idx,
                                                input logic signed [DELAY_W-1:0] delay);
      queue_rsp_type     rsp;
      logic [TIME_W-1:0] due;
      int                pos;
      rsp.out_index = '0;
      rsp.status    = STATUS_OK;
      case (f)
         FUNC_PUSH: begin
            if (held_count >= DEPTH) begin
               rsp.status = STATUS_FULL;
            end else begin
               // negative delay means due right now
               if (delay[DELAY_W-1])
                  due = tick_count;
               else
                  due = tick_count + {{(TIME_W-DELAY_W){1'b0}}, delay};
               pos = held_count;
               // ties stay behind older entries
               while (pos > 0 && lies_before(due, due_time[pos-1])) begin
                  due_time[pos]   = due_time[pos-1];
                  held_index[pos] = held_index[pos-1];
                  pos--;
               end
               due_time[pos]   = due;
               held_index[pos] = idx;
               held_count++;
            end
         end
         FUNC_TICK: begin
            tick_count = tick_count + 1'b1;
         end
         default: begin
            if (held_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else if (f == FUNC_POP && lies_before(tick_count, due_time[0])) begin
               rsp.status = STATUS_NOT_DUE;
            end else begin
               rsp.out_index = held_index[0];
               for (int i = 1; i < held_count; i++) begin
                  due_time[i-1]   = due_time[i];
                  held_index[i-1] = held_index[i];
               end
               held_count--;
            end
         end
      endcase
      rsp.occupancy = OCC_W'(held_count);
      return rsp;
   endfunction

   always @(posedge clock) begin
      queue_rsp_type want;
      if (reset) begin
         held_count = 0;
         tick_count = '0;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no request waiting: index %h status %0d occupancy %0d",
                        $time, rsp_out_index, rsp_status, rsp_occupancy);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_out_index !== want.out_index) begin
                  mismatch_count++;
                  $display("%0t: out_index expected %h actual %h",
                           $time, want.out_index, rsp_out_index);
               end
               if (rsp_status !== want.status) begin
                  mismatch_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_occupancy !== want.occupancy) begin
                  mismatch_count++;
                  $display("%0t: occupancy expected %0d actual %0d",
                           $time, want.occupancy, rsp_occupancy);
               end
            end
         end
         if (start && !busy)
            awaited_rsp.push_back(step_queue(func_type'(req_func), req_product_index,
                                             req_delay_ticks));
      end
      awaited_count = awaited_rsp.size();
   end

endmodule

// ===== verif/deadline_delay_queue_tb.sv =====
// deadline_delay_queue_tb: clock, reset and request traffic for the deadline delay queue, plus the verdict
`timescale 1ns / 1ps

module deadline_delay_queue_tb;
   import ddq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 750;
   localparam int IDLE_LIMIT   = 2000;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [1:0]                req_func;
   logic [INDEX_W-1:0]        req_product_index;
   logic signed [DELAY_W-1:0] req_delay_ticks;
   logic                      rsp_valid;
   logic [INDEX_W-1:0]        rsp_out_index;
   logic [1:0]                rsp_status;
   logic [OCC_W-1:0]          rsp_occupancy;
   int                        mismatch_count;
   int                        awaited_count;
   int                        burst_left;

   deadline_delay_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_product_index (req_product_index),
      .req_delay_ticks   (req_delay_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_out_index     (rsp_out_index),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy)
   );

   ddq_checker #(
      .DEPTH(QUEUE_DEPTH)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_product_index (req_product_index),
      .req_delay_ticks   (req_delay_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_out_index     (rsp_out_index),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy),
      .mismatch_count    (mismatch_count),
      .awaited_count     (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // requests go out in bursts; a gap of zero keeps start high across bursts
   task automatic send_request(input func_type f, input logic [INDEX_W-1:0] idx,
                               input int delay);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      start             <= 1'b1;
      req_func          <= f;
      req_product_index <= idx;
      req_delay_ticks   <= DELAY_W'(delay);
      do @(posedge clock); while (busy);
      burst_left--;
   endtask

   initial begin : stimulus
      int       fixed_delay [16];
      bit       fill_mode;
      int       pick;
      int       delay;
      func_type f;
      start             <= 1'b0;
      req_func          <= FUNC_PUSH;
      req_product_index <= '0;
      req_delay_ticks   <= '0;
      reset             <= 1'b1;
      burst_left = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty queue, then a fill with field extremes and tied due times
      send_request(FUNC_GET, '1, -1);
      send_request(FUNC_POP, '1, -1);
      send_request(FUNC_TICK, '0, 0);
      fixed_delay = '{0, 8388607, -8388608, -1, 1, 5, 5, 5, 2, 3, 100, 7, 7, 4, 6, 9};
      for (int i = 0; i < QUEUE_DEPTH; i++)
         send_request(FUNC_PUSH, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom,
                      fixed_delay[i]);
      send_request(FUNC_PUSH, $urandom, 0);
      // get takes the oldest of three due entries, two pops take the rest, next is not due
      send_request(FUNC_GET, '0, 0);
      send_request(FUNC_POP, '0, 0);
      send_request(FUNC_POP, '0, 0);
      send_request(FUNC_POP, '0, 0);
      send_request(FUNC_TICK, '0, 0);

      fill_mode = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 39) == 0)
            fill_mode = !fill_mode;
         pick = $urandom_range(0, 99);
         if (fill_mode)
            f = func_type'((pick < 55) ? FUNC_PUSH : (pick < 75) ? FUNC_TICK :
                           (pick < 92) ? FUNC_POP : FUNC_GET);
         else
            f = func_type'((pick < 15) ? FUNC_PUSH : (pick < 45) ? FUNC_TICK :
                           (pick < 85) ? FUNC_POP : FUNC_GET);
         case ($urandom_range(0, 9))
            0:       delay = $signed(DELAY_W'($urandom));
            1:       delay = -$urandom_range(1, 8);
            default: delay = $urandom_range(0, 12);
         endcase
         send_request(f, $urandom, delay);
      end
      start <= 1'b0;

      while (awaited_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
